FILE: sv/ebs_pkg.sv
// shared types and constants for the eviction batch sizer
package ebs_pkg;

    // store size and derived widths
    localparam int MAX_CLASSES = 64;
    localparam int ADDR_W      = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CNT_W       = $clog2(MAX_CLASSES + 1);

    // field widths
    localparam int PCT_W   = 15;
    localparam int MEM_W   = 40;
    localparam int ALLOC_W = 23;
    localparam int BATCH_W = 20;
    localparam int POS_W   = 6;
    localparam int RAW_W   = 48;
    localparam int NUM_W   = PCT_W + MEM_W;      // (watermark - free) * memory
    localparam int PROD_W  = BATCH_W + RAW_W;    // max_batch * raw
    localparam int CNT_DIV_W = 6;

    // divider step counts
    localparam int RAW_DIV_STEPS   = NUM_W - 8;  // quotient of (num >> 8) / alloc
    localparam int SCALE_DIV_STEPS = BATCH_W;    // quotient stays below 2^20

    // stream payload widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_HIGH_WATERMARK = 2'd0;
    localparam logic [1:0] REG_MAX_BATCH      = 2'd1;
    localparam logic [1:0] REG_MIN_BATCH      = 2'd2;

    // reset values
    localparam logic [PCT_W-1:0]   HIGH_WATERMARK_RST = PCT_W'(1280);
    localparam logic [BATCH_W-1:0] MAX_BATCH_RST      = BATCH_W'(40);
    localparam logic [BATCH_W-1:0] MIN_BATCH_RST      = BATCH_W'(5);

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIVA,
        ST_STORE,
        ST_RD,
        ST_SCALE,
        ST_DIVB,
        ST_OUT
    } state_t;

endpackage

FILE: sv/eviction_batch_sizer.sv
// eviction batch sizer: raw need per class, stored, then scaled results per run
// intake: one item at a time through accept, multiply, divider steps and store,
//   or accept, multiply and store with no division; the divider is shared and restoring
// emission: per class with nonzero need read, multiply, divider steps and output load;
//   read, multiply, output load with zero need; the load waits while the output stalls
// reset: synchronous active-low aresetn clears the sequencer, run count, maximum,
//   output valid and registers to their defaults; the need store needs no clearing
module eviction_batch_sizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [14:0] free_percent, [54:15] memory_size, [77:55] alloc_size, [79:78] zero
    input  logic [ebs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [19:0] batch_size, [25:20] class_position, [31:26] zero
    output logic [ebs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ebs_pkg::PADDR_W-1:0]   paddr,
    input  logic [ebs_pkg::PDATA_W-1:0]   pwdata,
    output logic [ebs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import ebs_pkg::*;

    state_t                state_reg, state_next;

    logic [PCT_W-1:0]      wm_reg, wm_next;
    logic [BATCH_W-1:0]    mb_reg, mb_next;
    logic [BATCH_W-1:0]    minb_reg, minb_next;

    logic [PCT_W-1:0]      diff_reg, diff_next;
    logic                  need_reg, need_next;
    logic [MEM_W-1:0]      mem_reg, mem_next;
    logic [ALLOC_W-1:0]    alloc_reg, alloc_next;
    logic                  last_reg, last_next;

    logic [RAW_W:0]        div_rem_reg, div_rem_next;
    logic [RAW_W-1:0]      div_dvd_reg, div_dvd_next;
    logic [RAW_W-1:0]      div_quo_reg, div_quo_next;
    logic [RAW_W-1:0]      div_dvs_reg, div_dvs_next;
    logic [CNT_DIV_W-1:0]  div_cnt_reg, div_cnt_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [RAW_W-1:0]      largest_reg, largest_next;
    logic [ADDR_W-1:0]     pos_reg, pos_next;
    logic                  zero_reg, zero_next;

    logic                  out_valid_reg, out_valid_next;
    logic [BATCH_W-1:0]    out_batch_reg, out_batch_next;
    logic [POS_W-1:0]      out_pos_reg, out_pos_next;
    logic                  out_last_reg, out_last_next;

    // need store
    logic [RAW_W-1:0]      raw_mem [MAX_CLASSES];
    logic [RAW_W-1:0]      rd_data_reg;
    logic                  mem_we;

    logic                  s_accept;
    logic                  cfg_write;
    logic                  out_free;
    logic                  run_end;
    logic                  last_class;
    logic [RAW_W:0]        div_trial;
    logic                  div_ge;
    logic [NUM_W-1:0]      num_prod;
    logic [PROD_W-1:0]     scale_prod;
    logic [BATCH_W-1:0]    scaled;
    logic [CNT_W-1:0]      count_inc;

    // handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - BATCH_W - POS_W){1'b0}}, out_pos_reg, out_batch_reg};
    assign m_tlast  = out_last_reg;

    // register read back
    always_comb begin
        case (paddr[3:2])
            REG_HIGH_WATERMARK: prdata = PDATA_W'(wm_reg);
            REG_MAX_BATCH:      prdata = PDATA_W'(mb_reg);
            REG_MIN_BATCH:      prdata = PDATA_W'(minb_reg);
            default:            prdata = '0;
        endcase
    end

    // shared divider step: shift in one dividend bit, subtract when it fits
    assign div_trial = {div_rem_reg[RAW_W-1:0], div_dvd_reg[RAW_W-1]};
    assign div_ge    = (div_trial >= {1'b0, div_dvs_reg});

    // multipliers, each feeding registers only
    assign num_prod   = diff_reg * mem_reg;
    assign scale_prod = mb_reg * rd_data_reg;

    // run bookkeeping
    assign count_inc  = count_reg + CNT_W'(1);
    assign run_end    = last_reg || (count_inc == CNT_W'(MAX_CLASSES));
    assign last_class = ((CNT_W'(pos_reg) + CNT_W'(1)) == count_reg);
    assign scaled     = div_quo_reg[BATCH_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_MUL;
            ST_MUL:   state_next = (need_reg && alloc_reg != '0) ? ST_DIVA : ST_STORE;
            ST_DIVA:  if (div_cnt_reg == CNT_DIV_W'(1)) state_next = ST_STORE;
            ST_STORE: state_next = run_end ? ST_RD : ST_IDLE;
            ST_RD:    state_next = ST_SCALE;
            ST_SCALE: state_next = (rd_data_reg == '0) ? ST_OUT : ST_DIVB;
            ST_DIVB:  if (div_cnt_reg == CNT_DIV_W'(1)) state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) state_next = last_class ? ST_IDLE : ST_RD;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        wm_next        = wm_reg;
        mb_next        = mb_reg;
        minb_next      = minb_reg;
        diff_next      = diff_reg;
        need_next      = need_reg;
        mem_next       = mem_reg;
        alloc_next     = alloc_reg;
        last_next      = last_reg;
        div_rem_next   = div_rem_reg;
        div_dvd_next   = div_dvd_reg;
        div_quo_next   = div_quo_reg;
        div_dvs_next   = div_dvs_reg;
        div_cnt_next   = div_cnt_reg;
        count_next     = count_reg;
        largest_next   = largest_reg;
        pos_next       = pos_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_batch_next = out_batch_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;

        // configuration writes
        if (cfg_write) begin
            case (paddr[3:2])
                REG_HIGH_WATERMARK: wm_next   = pwdata[PCT_W-1:0];
                REG_MAX_BATCH:      mb_next   = pwdata[BATCH_W-1:0];
                REG_MIN_BATCH:      minb_next = pwdata[BATCH_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            // capture item, watermark gap taken now
            ST_IDLE: begin
                if (s_accept) begin
                    need_next  = (s_tdata[PCT_W-1:0] < wm_reg);
                    diff_next  = wm_reg - s_tdata[PCT_W-1:0];
                    mem_next   = s_tdata[PCT_W +: MEM_W];
                    alloc_next = s_tdata[PCT_W + MEM_W +: ALLOC_W];
                    last_next  = s_tlast;
                end
            end
            // product into the divider, top bit first, or a known result
            ST_MUL: begin
                div_rem_next = '0;
                div_dvd_next = {num_prod[NUM_W-1:8], 1'b0};
                div_dvs_next = RAW_W'(alloc_reg);
                div_cnt_next = CNT_DIV_W'(RAW_DIV_STEPS);
                if (!need_reg) begin
                    div_quo_next = '0;
                end else if (alloc_reg == '0) begin
                    div_quo_next = '1;
                end else begin
                    div_quo_next = '0;
                end
            end
            ST_DIVA, ST_DIVB: begin
                div_rem_next = div_ge ? (div_trial - {1'b0, div_dvs_reg}) : div_trial;
                div_dvd_next = {div_dvd_reg[RAW_W-2:0], 1'b0};
                div_quo_next = {div_quo_reg[RAW_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg - CNT_DIV_W'(1);
            end
            // write need, track maximum
            ST_STORE: begin
                mem_we     = 1'b1;
                count_next = count_inc;
                if (div_quo_reg > largest_reg) largest_next = div_quo_reg;
                pos_next   = '0;
            end
            ST_RD: ;
            // scale against the largest need
            ST_SCALE: begin
                zero_next    = (rd_data_reg == '0);
                div_rem_next = {1'b0, scale_prod[PROD_W-1:BATCH_W]};
                div_dvd_next = {scale_prod[BATCH_W-1:0], {(RAW_W - BATCH_W){1'b0}}};
                div_dvs_next = largest_reg;
                div_cnt_next = CNT_DIV_W'(SCALE_DIV_STEPS);
                div_quo_next = '0;
            end
            // hand over to the output register
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_pos_next   = POS_W'(pos_reg);
                    out_last_next  = last_class;
                    if (zero_reg) begin
                        out_batch_next = '0;
                    end else begin
                        out_batch_next = (scaled < minb_reg) ? minb_reg : scaled;
                    end
                    if (last_class) begin
                        count_next   = '0;
                        largest_next = '0;
                    end else begin
                        pos_next = pos_reg + ADDR_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // need store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            raw_mem[count_reg[ADDR_W-1:0]] <= div_quo_reg;
        end
        rd_data_reg <= raw_mem[pos_reg];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wm_reg        <= HIGH_WATERMARK_RST;
            mb_reg        <= MAX_BATCH_RST;
            minb_reg      <= MIN_BATCH_RST;
            count_reg     <= '0;
            largest_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wm_reg        <= wm_next;
            mb_reg        <= mb_next;
            minb_reg      <= minb_next;
            count_reg     <= count_next;
            largest_reg   <= largest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        diff_reg      <= diff_next;
        need_reg      <= need_next;
        mem_reg       <= mem_next;
        alloc_reg     <= alloc_next;
        last_reg      <= last_next;
        div_rem_reg   <= div_rem_next;
        div_dvd_reg   <= div_dvd_next;
        div_quo_reg   <= div_quo_next;
        div_dvs_reg   <= div_dvs_next;
        div_cnt_reg   <= div_cnt_next;
        pos_reg       <= pos_next;
        zero_reg      <= zero_next;
        out_batch_reg <= out_batch_next;
        out_pos_reg   <= out_pos_next;
        out_last_reg  <= out_last_next;
    end

`ifndef SYNTHESIS
    // a run never holds a full store while waiting for items
    a_count_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (count_reg < CNT_W'(MAX_CLASSES)))
        else $error("run count reached store size while idle");

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVA || state_reg == ST_DIVB) |->
            (div_rem_reg < {1'b0, div_dvs_reg}))
        else $error("divider remainder out of range");

    // a stored need never exceeds the tracked maximum
    a_raw_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCALE) |-> (rd_data_reg <= largest_reg))
        else $error("stored need above run maximum");

    // handing over the final result closes the run
    a_run_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free && last_class) |=>
            (count_reg == '0 && largest_reg == '0 && m_tvalid && m_tlast))
        else $error("run not closed after final result");
`endif

endmodule

FILE: bench/eviction_batch_sizer_tb.sv
// self-checking testbench for the eviction batch sizer: stream stimulus, apb set-up, scoreboard
module eviction_batch_sizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ebs_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE_CYCLES = 60;     // time for one item in flight to finish
    localparam int HOLD_CYCLES  = 1500;    // long receiver hold-off
    localparam int HOLD_AFTER   = 20;      // results seen before the hold-off starts
    localparam int STALL_LIMIT  = 8000;    // cycles with no handshake of any kind

    localparam logic [MEM_W-1:0]   MEM_MAX   = {MEM_W{1'b1}};
    localparam logic [ALLOC_W-1:0] ALLOC_MAX = ALLOC_W'(4194304);
    localparam logic [PCT_W-1:0]   PCT_MAX   = PCT_W'(25600);
    localparam logic [BATCH_W-1:0] BATCH_MAX = {BATCH_W{1'b1}};

    typedef struct packed {
        logic [BATCH_W-1:0] batch;
        logic [POS_W-1:0]   pos;
        logic               fin;
    } batch_result_t;

    // scoreboard: own copy of registers and need store, expected results in order
    class batch_scoreboard;
        logic [PCT_W-1:0]   watermark;
        logic [BATCH_W-1:0] top_batch;
        logic [BATCH_W-1:0] floor_batch;
        logic [RAW_W-1:0]   need_store [MAX_CLASSES];
        logic [RAW_W-1:0]   peak_need;
        int unsigned        stored;
        batch_result_t      due_batches [$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        classes_taken;
        int unsigned        runs_closed;

        function new();
            watermark     = HIGH_WATERMARK_RST;
            top_batch     = MAX_BATCH_RST;
            floor_batch   = MIN_BATCH_RST;
            peak_need     = '0;
            stored        = 0;
            errors        = 0;
            checked       = 0;
            classes_taken = 0;
            runs_closed   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [PDATA_W-1:0] val);
            case (idx)
                REG_HIGH_WATERMARK: watermark   = val[PCT_W-1:0];
                REG_MAX_BATCH:      top_batch   = val[BATCH_W-1:0];
                REG_MIN_BATCH:      floor_batch = val[BATCH_W-1:0];
                default: ;
            endcase
        endfunction

        // raw need in percent scaling; a zero allocation size saturates when there is a need
        function logic [RAW_W-1:0] raw_need(logic [PCT_W-1:0] free, logic [MEM_W-1:0] mem,
                                            logic [ALLOC_W-1:0] alloc);
            logic [NUM_W-1:0] num;
            logic [NUM_W-1:0] quot;
            if (free >= watermark)
                return '0;
            if (alloc == '0)
                return {RAW_W{1'b1}};
            num  = NUM_W'(watermark - free) * NUM_W'(mem);
            quot = num / (NUM_W'(alloc) << 8);
            return quot[RAW_W-1:0];
        endfunction

        // share of max_batch in proportion to the largest need, floored at min_batch; a zero need gives zero
        function logic [BATCH_W-1:0] scaled_batch(logic [RAW_W-1:0] need);
            logic [PROD_W-1:0] prod;
            logic [PROD_W-1:0] quot;
            logic [BATCH_W-1:0] b;
            if (need == '0)
                return '0;
            prod = PROD_W'(top_batch) * PROD_W'(need);
            quot = prod / PROD_W'(peak_need);
            b    = quot[BATCH_W-1:0];
            if (b < floor_batch)
                b = floor_batch;
            return b;
        endfunction

        function void take_class(logic [PCT_W-1:0] free, logic [MEM_W-1:0] mem,
                                 logic [ALLOC_W-1:0] alloc, logic last);
            logic [RAW_W-1:0] need;
            batch_result_t r;
            need = raw_need(free, mem, alloc);
            classes_taken++;
            if (stored < MAX_CLASSES) begin
                need_store[stored] = need;
                stored++;
                if (need > peak_need)
                    peak_need = need;
            end
            // a full store closes the run whatever tlast says
            if (stored >= MAX_CLASSES)
                last = 1'b1;
            if (!last)
                return;
            for (int k = 0; k < stored; k++) begin
                r.batch = scaled_batch(need_store[k]);
                r.pos   = POS_W'(k);
                r.fin   = (k == stored - 1);
                due_batches.insert(due_batches.size(), r);
            end
            stored    = 0;
            peak_need = '0;
            runs_closed++;
        endfunction

        task report(string field, int unsigned pos, longint unsigned got, longint unsigned want);
            $display("result at class %0d, %s: got %0d, expected %0d", pos, field, got, want);
            errors++;
        endtask

        task check_batch(logic [M_TDATA_W-1:0] data, logic tl);
            batch_result_t want;
            logic [BATCH_W-1:0] got_batch;
            logic [POS_W-1:0]   got_pos;
            got_batch = data[BATCH_W-1:0];
            got_pos   = data[BATCH_W +: POS_W];
            checked++;
            if (due_batches.size() == 0) begin
                report("unexpected item", got_pos, got_batch, 0);
                return;
            end
            want = due_batches.pop_front();
            if (got_batch !== want.batch)
                report("batch_size", want.pos, got_batch, want.batch);
            if (got_pos !== want.pos)
                report("class_position", want.pos, got_pos, want.pos);
            if (tl !== want.fin)
                report("last_result", want.pos, tl, want.fin);
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    batch_scoreboard sb;
    int unsigned     burst_left;
    int unsigned     settings_used;

    eviction_batch_sizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // apb write: setup cycle, access cycle, then idle
    task reg_write(logic [1:0] idx, logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task apply_settings(logic [PCT_W-1:0] wm, logic [BATCH_W-1:0] mb, logic [BATCH_W-1:0] mn);
        reg_write(REG_HIGH_WATERMARK, PDATA_W'(wm));
        reg_write(REG_MAX_BATCH, PDATA_W'(mb));
        reg_write(REG_MIN_BATCH, PDATA_W'(mn));
        settings_used++;
    endtask

    // offer one item, hold until taken, then maybe open a gap between bursts
    task send_item(logic [PCT_W-1:0] free, logic [MEM_W-1:0] mem,
                   logic [ALLOC_W-1:0] alloc, logic last);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({alloc, mem, free});
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.take_class(free, mem, alloc, last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // random class with a bias towards free percentages at or below the watermark
    task make_class(output logic [PCT_W-1:0] free, output logic [MEM_W-1:0] mem,
                    output logic [ALLOC_W-1:0] alloc);
        logic [63:0] wide;
        case ($urandom_range(0, 7))
            0:       free = '0;
            1:       free = PCT_MAX;
            2, 3, 4: free = PCT_W'($urandom_range(0, sb.watermark));
            default: free = PCT_W'($urandom_range(0, 25600));
        endcase
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       mem = '0;
            1:       mem = MEM_MAX;
            default: mem = wide[MEM_W-1:0] >> $urandom_range(0, MEM_W - 1);
        endcase
        case ($urandom_range(0, 15))
            0:       alloc = '0;
            1:       alloc = ALLOC_MAX;
            2, 3, 4: alloc = ALLOC_W'(1) << $urandom_range(0, ALLOC_W - 1);
            5, 6, 7: alloc = ALLOC_W'($urandom_range(1, 64));
            default: alloc = ALLOC_W'($urandom_range(1, 4194304));
        endcase
    endtask

    // wait for every expected item, then for the block to go quiet
    task drain();
        s_tvalid <= 1'b0;
        while (sb.due_batches.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // random runs; full_kind 1 adds a run that fills the store without tlast,
    // full_kind 2 one that fills it with tlast on the final class
    task run_phase(int unsigned n_items, int unsigned full_kind);
        int unsigned left;
        int unsigned len;
        logic [PCT_W-1:0]   free;
        logic [MEM_W-1:0]   mem;
        logic [ALLOC_W-1:0] alloc;
        if (full_kind != 0) begin
            for (int k = 0; k < MAX_CLASSES; k++) begin
                make_class(free, mem, alloc);
                send_item(free, mem, alloc, full_kind == 2 && k == MAX_CLASSES - 1);
            end
        end
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
            if (len > left)
                len = left;
            for (int k = 0; k < len; k++) begin
                make_class(free, mem, alloc);
                send_item(free, mem, alloc, k == len - 1);
            end
            left -= len;
        end
        drain();
    endtask

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_batch(m_tdata, m_tlast);
    end

    // receiver: changing stall pattern, plus one long hold-off while results wait
    initial begin : receiver
        int unsigned cyc;
        int unsigned mode;
        bit          held;
        cyc      = 0;
        mode     = 0;
        held     = 1'b0;
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 97 == 0)
                mode = $urandom_range(0, 3);
            if (!held && m_tvalid && sb.checked >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (cyc % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no handshake at all
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("eviction_batch_sizer: mismatch");
        $finish;
    end

    initial begin : stimulus
        sb            = new();
        burst_left    = 0;
        settings_used = 1;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset settings: field extremes, zero needs, zero alloc saturating
        send_item('0, MEM_MAX, ALLOC_W'(1), 1'b0);
        send_item(PCT_MAX, MEM_MAX, ALLOC_MAX, 1'b0);
        send_item(PCT_W'(1279), MEM_W'(12345), ALLOC_MAX, 1'b0);
        send_item(PCT_W'(640), MEM_W'(40'h00_4000_0000), ALLOC_W'(3), 1'b0);
        send_item(PCT_W'(100), '0, ALLOC_W'(7), 1'b0);
        send_item(PCT_W'(1280), MEM_W'(999), '0, 1'b0);
        send_item('0, MEM_MAX, '0, 1'b1);
        // every need zero
        send_item(PCT_MAX, MEM_MAX, '0, 1'b0);
        send_item(PCT_W'(1280), MEM_MAX, ALLOC_W'(1), 1'b1);
        // single class run
        send_item(PCT_W'(1000), MEM_W'(1 << 20), ALLOC_W'(16), 1'b1);
        // tiny need next to a huge one, raised to min_batch
        send_item('0, MEM_MAX, ALLOC_W'(1), 1'b0);
        send_item(PCT_W'(1279), MEM_W'(25600), ALLOC_W'(1), 1'b0);
        send_item(PCT_W'(1279), MEM_W'(25600), ALLOC_W'(1), 1'b1);
        drain();

        // register settings, extremes first
        apply_settings(PCT_MAX, BATCH_MAX, '0);
        run_phase(20, 1);
        apply_settings('0, BATCH_MAX, BATCH_MAX);
        run_phase(12, 0);
        apply_settings(PCT_W'(12800), '0, BATCH_W'(3));
        run_phase(35, 0);
        apply_settings(PCT_MAX, BATCH_MAX, BATCH_MAX);
        run_phase(25, 0);
        apply_settings(PCT_W'($urandom_range(1, 25600)), BATCH_W'($urandom_range(1, 1048575)),
                       BATCH_W'($urandom_range(0, 64)));
        run_phase(50, 0);
        apply_settings(PCT_W'(6400), BATCH_W'(1000), BATCH_W'(1));
        run_phase(0, 2);

        $display("ran %0d classes in %0d runs under %0d register settings",
                 sb.classes_taken, sb.runs_closed, settings_used);
        $display("checked %0d result items, %0d failures", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.due_batches.size() == 0)
            $display("eviction_batch_sizer: match");
        else
            $display("eviction_batch_sizer: mismatch");
        $finish;
    end

endmodule
